@@ rtl/core/lru_key_value_cache_top_defines.svh @@
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// same-cycle implication
`define LKVC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lkvc check failed");

// next-cycle implication
`define LKVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkvc check failed");

`endif

@@ rtl/core/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Widths, reset constants, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int KEY_W           = 32;
  localparam int VAL_W           = 32;
  localparam int CAP_W           = 5;
  localparam int ENTRIES_DEFAULT = 16;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  // action codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lkvc_slot_t;

  // broadcast to every cell
  typedef struct packed {
    logic             accept;
    logic             insert;
    logic [KEY_W-1:0] key;
  } lkvc_req_t;

endpackage

`default_nettype wire

@@ rtl/core/lkvc_in_if.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache request channel
// Valid/ready channel carrying one get or set item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_in_if
  import lkvc_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [KEY_W-1:0] key;
  logic signed [VAL_W-1:0] write_value;

  modport source (output valid, action, key, write_value, input ready);
  modport sink   (input valid, action, key, write_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lkvc_out_if.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache response channel
// Valid/ready channel carrying one get result.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_out_if
  import lkvc_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [VAL_W-1:0] read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lru_key_value_cache_top.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative store kept in recency order by a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) takes one item: action 0 = get, 1 = set.
//   rsp channel (valid/ready) returns one item per get: hit flag and value,
//   all ones on a miss. A set returns nothing.
//   APB register 0 (byte address 0): capacity_in_use, 5 bits, reset 16;
//   0 acts as 1, above ENTRIES acts as ENTRIES. Write only while idle.
// Timing:
//   Every cell compares its key in parallel; the slot row moves to front in
//   the same cycle. A get result sits in the output register in the cycle after
//   the item is taken. One item per cycle sustained while the receiver keeps
//   up: compare and shift finish in the cycle the item is taken, and
//   req.ready follows rsp.ready while a result is waiting.
// Reset:
//   rst (synchronous) empties all slots, zeroes occupancy, restores
//   capacity to 16 and drops any waiting result.
// Stall:
//   with a result held and rsp.ready low, req.ready goes low; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_key_value_cache_top_defines.svh"

module lru_key_value_cache_top
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  lkvc_in_if.sink          req,
  lkvc_out_if.source       rsp
);

  localparam int CW   = $clog2(ENTRIES + 1);           // occupancy width
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;     // capacity compare width

  // ---- configuration ----
  logic [CAP_W-1:0] capacity;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write && (paddr[2] == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = 32'(capacity);
    end
  end

  // effective capacity clamped to 1..ENTRIES
  logic [CMPW-1:0] cap_wide;
  logic [CW-1:0]   eff_cap;

  always_comb begin
    cap_wide = CMPW'(capacity);
    if (cap_wide == '0) begin
      eff_cap = CW'(1);
    end else if (cap_wide > CMPW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = CW'(cap_wide);
    end
  end

  // ---- request decode ----
  logic             accept;
  logic             any_hit;
  logic [VAL_W-1:0] hit_value;
  logic [VAL_W-1:0] front_value;
  logic             insert;
  logic [CW-1:0]    occ;
  logic [CW-1:0]    base;
  lkvc_req_t        cell_req;
  lkvc_slot_t       front;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign insert      = (req.action == ACT_SET) && !any_hit;
  assign front_value = (req.action == ACT_SET) ? req.write_value : hit_value;

  // full: drop the oldest entries so the new one fits within capacity
  assign base = (occ >= eff_cap) ? (eff_cap - CW'(1)) : occ;

  assign cell_req.accept = accept;
  assign cell_req.insert = insert;
  assign cell_req.key    = req.key;

  assign front.valid = 1'b1;
  assign front.key   = req.key;
  assign front.value = front_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (accept && insert) begin
      occ <= base + CW'(1);
    end
  end

  // ---- cell row, slot 0 most recent ----
  lkvc_slot_t       slots    [ENTRIES];
  lkvc_slot_t       chain_in [ENTRIES];
  logic [VAL_W-1:0] mvals    [ENTRIES];
  logic [ENTRIES-1:0] found_vec;
  logic [ENTRIES-1:0] found_in;
  logic [ENTRIES-1:0] below;
  logic [ENTRIES-1:0] valid_vec;

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      localparam logic [CW-1:0] POS = CW'(gi);

      if (gi == 0) begin : g_head
        assign chain_in[gi] = front;
      end else begin : g_body
        assign chain_in[gi] = slots[gi-1];
      end

      if (gi == ENTRIES - 1) begin : g_tail
        assign found_in[gi] = 1'b0;
      end else begin : g_link
        assign found_in[gi] = found_vec[gi+1];
      end

      assign below[gi]     = (POS <= base);
      assign valid_vec[gi] = slots[gi].valid;

      lkvc_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .req        (cell_req),
        .below_base (below[gi]),
        .prev       (chain_in[gi]),
        .found_in   (found_in[gi]),
        .found_out  (found_vec[gi]),
        .match_value(mvals[gi]),
        .slot       (slots[gi])
      );
    end
  endgenerate

  assign any_hit = found_vec[0];

  // valid keys are unique, so at most one cell drives a value
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | mvals[i];
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept && (req.action == ACT_GET)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req.action == ACT_GET)) begin
      rsp.hit        <= any_hit;
      rsp.read_value <= any_hit ? hit_value : MISS_VALUE;
    end
  end

  // ---- checks ----
  `LKVC_ASSERT_NOW(a_miss_all_ones, clk, rst, rsp.valid && !rsp.hit,
                   rsp.read_value == MISS_VALUE)
  `LKVC_ASSERT_NOW(a_occ_matches_valid, clk, rst, 1'b1,
                   $countones(valid_vec) == int'(occ))
  `LKVC_ASSERT_NEXT(a_get_hit_to_front, clk, rst,
                    accept && (req.action == ACT_GET) && any_hit,
                    slots[0].valid && (slots[0].key == $past(req.key)) &&
                    (slots[0].value == rsp.read_value))
  `LKVC_ASSERT_NEXT(a_set_to_front, clk, rst, accept && (req.action == ACT_SET),
                    slots[0].valid && (slots[0].key == $past(req.key)) &&
                    (slots[0].value == $past(req.write_value)))

endmodule

`default_nettype wire

@@ rtl/core/lkvc_cell.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache cell
// One recency slot: key compare, match chain, shift from the newer neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_cell
  import lkvc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lkvc_req_t        req,
  input  wire logic             below_base,  // slot index <= insert base
  input  wire lkvc_slot_t       prev,        // newer neighbour (or new item at slot 0)
  input  wire logic             found_in,    // match in an older slot
  output logic                  found_out,
  output logic [VAL_W-1:0]      match_value,
  output lkvc_slot_t            slot
);

  lkvc_slot_t slot_q;
  lkvc_slot_t slot_next;
  logic       match;
  logic       take;

  assign match       = slot_q.valid && (slot_q.key == req.key);
  assign found_out   = found_in | match;
  assign match_value = match ? slot_q.value : '0;
  assign slot        = slot_q;

  // hit: every slot up to and including the hit moves down one
  // insert: every slot up to the base moves down one
  assign take = req.accept && (req.insert ? below_base : found_out);

  always_comb begin
    slot_next = slot_q;
    if (take) begin
      slot_next.key   = prev.key;
      slot_next.value = prev.value;
    end
    if (req.accept && req.insert) begin
      slot_next.valid = below_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_q.valid <= 1'b0;
      slot_q.key   <= '0;
      slot_q.value <= '0;
    end else begin
      slot_q <= slot_next;
    end
  end

endmodule

`default_nettype wire
